FILE: hdl/aue_pkg.sv
// ----------------------------------------------------------------------------
// aue_pkg
// Shared types, codes and helpers of the Annex B unit extractor.
// ----------------------------------------------------------------------------
package aue_pkg;

   localparam int ZERO_COUNT_MAX_DEF = 255;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   localparam logic OUT_PAYLOAD = 1'b0;
   localparam logic OUT_END     = 1'b1;

   localparam logic [7:0] EMU_BYTE   = 8'h03;
   localparam logic [5:0] VCL_LIMIT  = 6'd32;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic              out_kind;
      logic [7:0]        data_byte;
      logic [5:0]        unit_type;
      logic [5:0]        layer_id;
      logic signed [3:0] temporal_id;
      logic              is_vcl;
      logic [7:0]        leading_zero_count;
      logic [7:0]        trailing_zero_count;
      logic              forbidden_bit_error;
      logic              escape_error;
      logic              last;
   } row_type;

   function automatic row_type make_row(input logic kind, input logic [7:0] data,
                                        input logic [7:0] trail, input logic esc,
                                        input logic [15:0] hdr, input logic [7:0] lead);
      row_type r;
      r.out_kind            = kind;
      r.data_byte           = data;
      r.unit_type           = hdr[14:9];
      r.layer_id            = hdr[8:3];
      r.temporal_id         = signed'(4'({1'b0, hdr[2:0]}) + 4'hF);
      r.is_vcl              = (hdr[14:9] < VCL_LIMIT);
      r.leading_zero_count  = lead;
      r.trailing_zero_count = trail;
      r.forbidden_bit_error = hdr[15];
      r.escape_error        = esc;
      r.last                = 1'b0;
      return r;
   endfunction

endpackage

FILE: hdl/aue_req_if.sv
// ----------------------------------------------------------------------------
// aue_req_if
// Input channel: one Annex B stream byte or end-of-stream marker.
// ----------------------------------------------------------------------------
interface aue_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_byte;

   modport source (output valid, output kind, output in_byte, input ready);
   modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

FILE: hdl/aue_rsp_if.sv
// ----------------------------------------------------------------------------
// aue_rsp_if
// Result channel: payload byte or end record of a unit.
// ----------------------------------------------------------------------------
interface aue_rsp_if;
   logic              valid;
   logic              ready;
   logic              out_kind;
   logic [7:0]        data_byte;
   logic [5:0]        unit_type;
   logic [5:0]        layer_id;
   logic signed [3:0] temporal_id;
   logic              is_vcl;
   logic [7:0]        leading_zero_count;
   logic [7:0]        trailing_zero_count;
   logic              forbidden_bit_error;
   logic              escape_error;
   logic              last;

   modport source (output valid, output out_kind, output data_byte, output unit_type,
                   output layer_id, output temporal_id, output is_vcl,
                   output leading_zero_count, output trailing_zero_count,
                   output forbidden_bit_error, output escape_error, output last,
                   input ready);
   modport sink   (input valid, input out_kind, input data_byte, input unit_type,
                   input layer_id, input temporal_id, input is_vcl,
                   input leading_zero_count, input trailing_zero_count,
                   input forbidden_bit_error, input escape_error, input last,
                   output ready);
endinterface

FILE: hdl/annexb_nal_unit_extractor_core.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_extractor_core
// H.265 Annex B unit extractor: start code search, header capture,
// emulation-prevention removal and end records with zero counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one transaction per stream byte (kind = 0) or an
//   end-of-stream marker (kind = 1). rsp_ch carries payload bytes and one
//   end record per unit; last marks the final result of an input transaction.
//   A transaction is decoded in the cycle it is accepted: parser state is
//   updated and its zero to three results are written into a four-entry
//   result queue. Results are registered in the queue, and rsp_ch shows the
//   entry at its head.
//   Throughput is one input transaction per cycle while each one yields at
//   most one result and rsp_ch.ready stays high. The queue drains one
//   result per cycle while rsp_ch.ready is high, so three results (00 00 xx
//   released at once) leave in order. req_ch.ready is high while at most
//   one result is queued. If the receiver stalls, results stay in the
//   queue and req_ch.ready drops once two are waiting; nothing is lost.
//   Synchronous reset empties the queue and returns the parser to start code
//   search with all counts cleared.
// ----------------------------------------------------------------------------
module annexb_nal_unit_extractor_core #(
   parameter int ZERO_COUNT_MAX = aue_pkg::ZERO_COUNT_MAX_DEF
) (
   input logic       clock,
   input logic       reset,
   aue_req_if.sink   req_ch,
   aue_rsp_if.source rsp_ch
);
   import aue_pkg::*;

   localparam int ZR_W = $clog2(ZERO_COUNT_MAX + 1);

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_UNIT   = 2'd1;
   localparam logic [1:0] PH_AFTER  = 2'd2;

   logic [1:0]     phase_ff, phase_in;
   logic [ZR_W-1:0] zero_run_ff, zero_run_in;
   logic [1:0]     held_ff, held_in;
   logic [1:0]     hdr_seen_ff, hdr_seen_in;
   logic [15:0]    hdr_ff, hdr_in;
   logic [7:0]     lead_ff, lead_in;
   logic           esc_ff, esc_in;
   logic           after_esc_ff, after_esc_in;

   row_type        rows [3];
   logic [1:0]     n_rows;
   logic           go_out;
   logic [7:0]     b;

   row_type               queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;

   logic accept;
   logic pop;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign b      = req_ch.in_byte;

   always_comb begin
      phase_in     = phase_ff;
      zero_run_in  = zero_run_ff;
      held_in      = held_ff;
      hdr_seen_in  = hdr_seen_ff;
      hdr_in       = hdr_ff;
      lead_in      = lead_ff;
      esc_in       = esc_ff;
      after_esc_in = after_esc_ff;
      n_rows       = 2'd0;
      go_out       = 1'b0;
      for (int k = 0; k < 3; k++) begin
         rows[k] = '0;
      end

      if (req_ch.kind == KIND_EOS) begin
         if (phase_ff == PH_UNIT) begin
            rows[n_rows] = make_row(OUT_END, 8'd0, 8'(held_ff), esc_ff, hdr_ff, lead_ff);
            n_rows = n_rows + 2'd1;
         end else if (phase_ff == PH_AFTER) begin
            rows[n_rows] = make_row(OUT_END, 8'd0, 8'(zero_run_ff), esc_ff, hdr_ff,
                                    lead_ff);
            n_rows = n_rows + 2'd1;
         end
         phase_in     = PH_SEARCH;
         zero_run_in  = '0;
         held_in      = 2'd0;
         after_esc_in = 1'b0;
      end else begin
         go_out = (phase_ff != PH_UNIT);
         if (phase_ff == PH_UNIT) begin
            if (hdr_seen_ff < 2'd2) begin
               if (hdr_seen_ff == 2'd0) begin
                  hdr_in[15:8] = hdr_ff[15:8] | b;
               end else begin
                  hdr_in[7:0] = hdr_ff[7:0] | b;
               end
               hdr_seen_in = hdr_seen_ff + 2'd1;
            end else begin
               if (after_esc_ff) begin
                  if (b > EMU_BYTE) begin
                     esc_in = 1'b1;
                  end
                  after_esc_in = 1'b0;
               end
               if (held_ff == 2'd2 && b <= 8'd2) begin
                  phase_in    = PH_AFTER;
                  zero_run_in = ZR_W'(2);
                  held_in     = 2'd0;
                  go_out      = 1'b1;
               end else if (held_ff == 2'd2 && b == EMU_BYTE) begin
                  rows[0]      = make_row(OUT_PAYLOAD, 8'd0, 8'd0, 1'b0, hdr_ff, lead_ff);
                  rows[1]      = rows[0];
                  n_rows       = 2'd2;
                  held_in      = 2'd0;
                  after_esc_in = 1'b1;
               end else if (b == 8'd0) begin
                  held_in = held_ff + 2'd1;
               end else begin
                  rows[0] = make_row(OUT_PAYLOAD, 8'd0, 8'd0, 1'b0, hdr_ff, lead_ff);
                  rows[1] = rows[0];
                  n_rows  = (held_ff > 2'd2) ? 2'd2 : held_ff;
                  rows[n_rows] = make_row(OUT_PAYLOAD, b, 8'd0, 1'b0, hdr_ff, lead_ff);
                  n_rows  = n_rows + 2'd1;
                  held_in = 2'd0;
               end
            end
         end

         if (go_out) begin
            if (b == 8'd0) begin
               if (zero_run_in < ZR_W'(ZERO_COUNT_MAX)) begin
                  zero_run_in = zero_run_in + ZR_W'(1);
               end
            end else if (b == 8'd1 && zero_run_in >= ZR_W'(2)) begin
               if (phase_in == PH_AFTER) begin
                  rows[n_rows] = make_row(OUT_END, 8'd0,
                                          (zero_run_in >= ZR_W'(3)) ?
                                             8'(zero_run_in - ZR_W'(3)) : 8'd0,
                                          esc_in, hdr_ff, lead_ff);
                  n_rows  = n_rows + 2'd1;
                  lead_in = (zero_run_in >= ZR_W'(3)) ? 8'd1 : 8'd0;
               end else begin
                  lead_in = 8'(zero_run_in - ZR_W'(2));
               end
               phase_in     = PH_UNIT;
               zero_run_in  = '0;
               held_in      = 2'd0;
               hdr_seen_in  = 2'd0;
               hdr_in       = 16'd0;
               esc_in       = 1'b0;
               after_esc_in = 1'b0;
            end else begin
               if (phase_in == PH_AFTER) begin
                  rows[n_rows] = make_row(OUT_END, 8'd0, 8'(zero_run_in), esc_in, hdr_ff,
                                          lead_ff);
                  n_rows = n_rows + 2'd1;
               end
               phase_in    = PH_SEARCH;
               zero_run_in = '0;
            end
         end
      end

      if (n_rows != 2'd0) begin
         rows[n_rows - 2'd1].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         zero_run_ff  <= '0;
         held_ff      <= 2'd0;
         hdr_seen_ff  <= 2'd0;
         hdr_ff       <= 16'd0;
         lead_ff      <= 8'd0;
         esc_ff       <= 1'b0;
         after_esc_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         zero_run_ff  <= zero_run_in;
         held_ff      <= held_in;
         hdr_seen_ff  <= hdr_seen_in;
         hdr_ff       <= hdr_in;
         lead_ff      <= lead_in;
         esc_ff       <= esc_in;
         after_esc_ff <= after_esc_in;
      end
   end

   // result queue
   assign req_ch.ready = (count_ff <= RSP_CNT_W'(1));
   assign count_in     = count_ff + (accept ? RSP_CNT_W'(n_rows) : '0) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(n_rows);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            if (2'(k) < n_rows) begin
               queue_ff[wr_ptr_ff + RSP_PTR_W'(k)] <= rows[k];
            end
         end
      end
   end

   assign rsp_ch.valid               = (count_ff != '0);
   assign rsp_ch.out_kind            = queue_ff[rd_ptr_ff].out_kind;
   assign rsp_ch.data_byte           = queue_ff[rd_ptr_ff].data_byte;
   assign rsp_ch.unit_type           = queue_ff[rd_ptr_ff].unit_type;
   assign rsp_ch.layer_id            = queue_ff[rd_ptr_ff].layer_id;
   assign rsp_ch.temporal_id         = queue_ff[rd_ptr_ff].temporal_id;
   assign rsp_ch.is_vcl              = queue_ff[rd_ptr_ff].is_vcl;
   assign rsp_ch.leading_zero_count  = queue_ff[rd_ptr_ff].leading_zero_count;
   assign rsp_ch.trailing_zero_count = queue_ff[rd_ptr_ff].trailing_zero_count;
   assign rsp_ch.forbidden_bit_error = queue_ff[rd_ptr_ff].forbidden_bit_error;
   assign rsp_ch.escape_error        = queue_ff[rd_ptr_ff].escape_error;
   assign rsp_ch.last                = queue_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> count_ff <= RSP_CNT_W'(1))
      else $error("transaction accepted without queue room");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_UNIT |-> held_ff == 2'd0 && !after_esc_ff)
      else $error("held zeros or escape pending outside a unit");

   a_held_max: assert property (@(posedge clock) disable iff (reset)
      held_ff <= 2'd2)
      else $error("more than two zero bytes held");

   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.kind == KIND_BYTE && phase_ff == PH_UNIT && hdr_seen_ff < 2'd2
         |-> n_rows == 2'd0)
      else $error("result produced during header capture");

endmodule
